// File: hdl/sbfd_pkg.sv
// Shared types and constants for the SBUS frame decoder.
// Used by every module of the block; depends on nothing.
package sbfd_pkg;

  // Frame layout
  localparam int unsigned NUM_CHANNELS  = 16;
  localparam int unsigned CHAN_W        = 11;
  localparam int unsigned CHAN_IDX_W    = 4;
  localparam int unsigned PAYLOAD_BYTES = 22;
  localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int unsigned FLAG_POS      = 23;
  localparam int unsigned LAST_POS      = 24;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned FAILSAFE_BIT  = 3;
  localparam int unsigned LOST_BIT      = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 8;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [7:0] START_MARKER_RST  = 8'h0F;
  localparam logic [7:0] END_MARKER_RST    = 8'h00;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_IDX_W-1:0] channel_index;
    logic [CHAN_W-1:0]     channel_value;
    logic                  failsafe_flag;
    logic                  lost_flag;
    logic                  frame_valid;
    logic                  last_of_frame;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_FLAG    = 2'd1,
    CMD_END_OK  = 2'd2,
    CMD_END_BAD = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } back_state_e;

endpackage

// File: hdl/sbfd_front.sv
// Front end: accepts frame bytes, tracks byte position and marker checks,
// and turns each later byte of a frame into a queue command. Depends on sbfd_pkg.
module sbfd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sbfd_pkg::in_item_t              in_item_i,
  output logic                            push_o,
  output sbfd_pkg::cmd_t                  push_cmd_o,
  input  logic                            full_i
);

  logic [7:0]                 start_marker_q, end_marker_q;
  logic [sbfd_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       active_q, active_d;
  logic                       matched_q, matched_d;
  logic                       accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Marker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= sbfd_pkg::START_MARKER_RST;
      end_marker_q   <= sbfd_pkg::END_MARKER_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sbfd_pkg::REG_START_MARKER) begin
        start_marker_q <= cfg_data_i[7:0];
      end
      if (cfg_idx_i == sbfd_pkg::REG_END_MARKER) begin
        end_marker_q <= cfg_data_i[7:0];
      end
    end
  end

  // Byte classification
  always_comb begin
    pos_d      = pos_q;
    active_d   = active_q;
    matched_d  = matched_q;
    push_o     = 1'b0;
    push_cmd_o.kind = sbfd_pkg::CMD_DATA;
    push_cmd_o.data = in_item_i.data_byte;
    if (accept) begin
      if (in_item_i.frame_start) begin
        // start always wins, the frame in progress is dropped
        matched_d = (in_item_i.data_byte == start_marker_q);
        active_d  = 1'b1;
        pos_d     = sbfd_pkg::POS_W'(1);
      end else if (active_q) begin
        push_o = 1'b1;
        if (pos_q <= sbfd_pkg::POS_W'(sbfd_pkg::PAYLOAD_BYTES)) begin
          pos_d = pos_q + sbfd_pkg::POS_W'(1);
        end else if (pos_q == sbfd_pkg::POS_W'(sbfd_pkg::FLAG_POS)) begin
          push_cmd_o.kind = sbfd_pkg::CMD_FLAG;
          pos_d           = pos_q + sbfd_pkg::POS_W'(1);
        end else begin
          // last byte: check both markers
          active_d = 1'b0;
          pos_d    = '0;
          if (matched_q && (in_item_i.data_byte == end_marker_q)) begin
            push_cmd_o.kind = sbfd_pkg::CMD_END_OK;
          end else begin
            push_cmd_o.kind = sbfd_pkg::CMD_END_BAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      active_q  <= 1'b0;
      matched_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      active_q  <= active_d;
      matched_q <= matched_d;
    end
  end

endmodule

// File: hdl/sbfd_fifo.sv
// Small command queue between the front and back ends.
// Depends on sbfd_pkg for the command type.
module sbfd_fifo #(
  parameter int unsigned DEPTH = sbfd_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sbfd_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sbfd_pkg::cmd_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sbfd_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/sbfd_back.sv
// Back end: executes queue commands, keeps the packed payload and flag byte,
// and emits channel results through an output register. Depends on sbfd_pkg.
module sbfd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  sbfd_pkg::cmd_t        head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sbfd_pkg::out_item_t   out_item_o
);

  localparam int unsigned PW = sbfd_pkg::PAYLOAD_W;
  localparam int unsigned CW = sbfd_pkg::CHAN_W;

  sbfd_pkg::back_state_e  state_q, state_d;
  logic [sbfd_pkg::CHAN_IDX_W-1:0] ch_q, ch_d;
  // Payload shift line: first data byte ends up in the low byte,
  // channel extraction shifts right by one channel width at a time.
  logic [PW-1:0]          payload_q, payload_d;
  logic [7:0]             flag_q, flag_d;
  logic                   out_valid_q, out_valid_d;
  sbfd_pkg::out_item_t    out_item_q, out_item_d;
  logic                   slot_free;
  sbfd_pkg::out_item_t    chan_item;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Result for the channel at the bottom of the shift line
  always_comb begin
    chan_item.channel_index = ch_q;
    chan_item.channel_value = payload_q[CW-1:0];
    chan_item.failsafe_flag = flag_q[sbfd_pkg::FAILSAFE_BIT];
    chan_item.lost_flag     = flag_q[sbfd_pkg::LOST_BIT];
    chan_item.frame_valid   = 1'b1;
    chan_item.last_of_frame = (ch_q == sbfd_pkg::CHAN_IDX_W'(sbfd_pkg::NUM_CHANNELS - 1));
  end

  // Command execution and result sequencing
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    payload_d   = payload_q;
    flag_d      = flag_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    case (state_q)
      sbfd_pkg::BK_IDLE: begin
        if (!empty_i) begin
          case (head_i.kind)
            sbfd_pkg::CMD_DATA: begin
              pop_o     = 1'b1;
              payload_d = {head_i.data, payload_q[PW-1:8]};
            end
            sbfd_pkg::CMD_FLAG: begin
              pop_o  = 1'b1;
              flag_d = head_i.data;
            end
            sbfd_pkg::CMD_END_BAD: begin
              if (slot_free) begin
                pop_o       = 1'b1;
                out_valid_d = 1'b1;
                out_item_d  = '0;
                out_item_d.last_of_frame = 1'b1;
              end
            end
            sbfd_pkg::CMD_END_OK: begin
              // channel 0 goes out now, the rest follow from BK_EMIT
              if (slot_free) begin
                pop_o       = 1'b1;
                out_valid_d = 1'b1;
                out_item_d  = chan_item;
                payload_d   = {{CW{1'b0}}, payload_q[PW-1:CW]};
                ch_d        = ch_q + sbfd_pkg::CHAN_IDX_W'(1);
                state_d     = sbfd_pkg::BK_EMIT;
              end
            end
            default: begin
              pop_o = 1'b0;
            end
          endcase
        end
      end
      sbfd_pkg::BK_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_item_d  = chan_item;
          payload_d   = {{CW{1'b0}}, payload_q[PW-1:CW]};
          ch_d        = ch_q + sbfd_pkg::CHAN_IDX_W'(1);
          if (chan_item.last_of_frame) begin
            state_d = sbfd_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_d = sbfd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbfd_pkg::BK_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    payload_q  <= payload_d;
    flag_q     <= flag_d;
    out_item_q <= out_item_d;
  end

endmodule

// File: hdl/sbus_frame_decoder.sv
// Channel   | Direction | Handshake              | Payload
// cfg       | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
// in        | in        | in_valid_i / in_stall_o| in_item_i (data_byte, frame_start)
// out       | out       | out_valid_o/out_stall_i| out_item_o (channel result)
//
// An input byte is taken whenever the command queue has room.
// A good frame end makes the back end emit 16 results, one per cycle while
// the output is not stalled; a bad frame end emits one result.
// The queue (QUEUE_DEPTH entries) keeps taking bytes while results drain.
// Reset clears control state only; no clearing pass is needed.
// Top level: front end, command queue, back end. Depends on sbfd_pkg.
module sbus_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = sbfd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sbfd_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sbfd_pkg::out_item_t             out_item_o
);

  logic           push, full, pop, empty;
  sbfd_pkg::cmd_t push_cmd, head;

  sbfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  sbfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  sbfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hdl/sbfd_checker.sv
// Port-level checks for the SBUS frame decoder, bound to the top level.
// Depends on sbfd_pkg and sbus_frame_decoder.
module sbfd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input sbfd_pkg::out_item_t             out_item_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // a failed frame gives one result, zero but for last_of_frame, that closes the frame
  a_bad_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.frame_valid |->
      out_item_o.last_of_frame && (out_item_o.channel_index == '0) &&
      (out_item_o.channel_value == '0) && !out_item_o.failsafe_flag &&
      !out_item_o.lost_flag)
    else $error("malformed invalid-frame result");

  // a good frame closes on its last channel
  a_good_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_valid |->
      out_item_o.last_of_frame ==
      (out_item_o.channel_index ==
       sbfd_pkg::CHAN_IDX_W'(sbfd_pkg::NUM_CHANNELS - 1)))
    else $error("last_of_frame not on final channel");

endmodule

bind sbus_frame_decoder sbfd_checker u_sbfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// File: tb/tb_sbus_frame_decoder.sv
// Self-checking testbench for sbus_frame_decoder: random SBUS frames with bursty
// request traffic, a stalling receiver and marker reprogramming between phases.
// Depends on sbfd_pkg and the sbus_frame_decoder RTL only.
module tb_sbus_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import sbfd_pkg::*;

  // Spare register indexes; writes to them must have no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 64;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_MIXED} fill_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_ALTERNATE, STALL_HEAVY} stall_mode_e;

  // Tracks the decoder state and holds the channel results still owed
  class frame_scoreboard;
    logic [7:0]       start_marker;
    logic [7:0]       end_marker;
    logic [POS_W-1:0] byte_pos;
    bit               frame_active;
    bit               start_matched;
    logic [7:0]       payload [PAYLOAD_BYTES];
    logic [7:0]       flags;
    out_item_t        pending_channels [$];
    int unsigned      mismatches;

    function new();
      start_marker  = START_MARKER_RST;
      end_marker    = END_MARKER_RST;
      byte_pos      = '0;
      frame_active  = 1'b0;
      start_matched = 1'b0;
      foreach (payload[i]) payload[i] = 8'h00;
      flags      = 8'h00;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == REG_START_MARKER) start_marker = val;
      else if (idx == REG_END_MARKER) end_marker = val;
    endfunction

    // Advance the frame state by one accepted request; queue what a frame end yields
    function void take_byte(in_item_t req);
      logic [PAYLOAD_W-1:0] packed_bits;
      out_item_t            res;
      if (req.frame_start) begin
        start_matched = (req.data_byte == start_marker);
        frame_active  = 1'b1;
        byte_pos      = 5'd1;
        return;
      end
      if (!frame_active) return;
      if (byte_pos <= 5'(PAYLOAD_BYTES)) begin
        payload[byte_pos - 5'd1] = req.data_byte;
        byte_pos++;
        return;
      end
      if (byte_pos == 5'(FLAG_POS)) begin
        flags = req.data_byte;
        byte_pos++;
        return;
      end
      // end byte
      frame_active = 1'b0;
      byte_pos     = '0;
      if (!(start_matched && req.data_byte == end_marker)) begin
        res = '0;
        res.last_of_frame = 1'b1;
        pending_channels.push_back(res);
        return;
      end
      for (int i = 0; i < PAYLOAD_BYTES; i++) packed_bits[8*i +: 8] = payload[i];
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        res.channel_index = CHAN_IDX_W'(k);
        res.channel_value = packed_bits[CHAN_W*k +: CHAN_W];
        res.failsafe_flag = flags[FAILSAFE_BIT];
        res.lost_flag     = flags[LOST_BIT];
        res.frame_valid   = 1'b1;
        res.last_of_frame = (k == NUM_CHANNELS - 1);
        pending_channels.push_back(res);
      end
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_channel(out_item_t got);
      out_item_t want;
      if (pending_channels.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_channels.pop_front();
      compare_field("channel_index", 16'(want.channel_index), 16'(got.channel_index));
      compare_field("channel_value", 16'(want.channel_value), 16'(got.channel_value));
      compare_field("failsafe_flag", 16'(want.failsafe_flag), 16'(got.failsafe_flag));
      compare_field("lost_flag", 16'(want.lost_flag), 16'(got.lost_flag));
      compare_field("frame_valid", 16'(want.frame_valid), 16'(got.frame_valid));
      compare_field("last_of_frame", 16'(want.last_of_frame), 16'(got.last_of_frame));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;

  frame_scoreboard sb;
  int              burst_left = 0;
  int              items_sent = 0;
  bit              hold_off_req = 1'b0;

  sbus_frame_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one request, opening a new burst, mostly after a random gap, when the last one ran out
  task automatic send_byte(input logic [7:0] b, input logic s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= '{data_byte: b, frame_start: s};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_byte(in_item_i);
    items_sent++;
  endtask

  // Bytes 0 .. cut_at-1 of a frame; cut_at above the end byte sends it whole
  task automatic send_frame(input logic [7:0] lead_byte, input logic [7:0] flag_val,
                            input logic [7:0] tail_byte, input int cut_at, input fill_e fill);
    logic [7:0] b;
    for (int p = 0; p < cut_at && p <= LAST_POS; p++) begin
      if (p == 0) b = lead_byte;
      else if (p == FLAG_POS) b = flag_val;
      else if (p == LAST_POS) b = tail_byte;
      else begin
        case (fill)
          FILL_ZEROS: b = 8'h00;
          FILL_ONES:  b = 8'hFF;
          FILL_MIXED: begin
            case ($urandom_range(0, 2))
              0:       b = 8'h00;
              1:       b = 8'hFF;
              default: b = 8'($urandom);
            endcase
          end
          default:    b = 8'($urandom);
        endcase
      end
      send_byte(b, p == 0);
    end
  endtask

  // Stop offering and wait until every owed result is out and the block is quiet
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_channels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both markers, then the spare indexes, which must leave the markers alone
  task automatic program_markers(input logic [7:0] start_val, input logic [7:0] end_val);
    logic [CFG_IDX_W-1:0] idx_seq [4];
    logic [7:0]           val_seq [4];
    idx_seq = '{REG_START_MARKER, REG_END_MARKER, REG_SPARE_2, REG_SPARE_3};
    val_seq = '{start_val, end_val, 8'($urandom), 8'($urandom)};
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_idx_i  <= idx_seq[i];
      cfg_data_i <= val_seq[i];
      sb.write_reg(idx_seq[i], val_seq[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: stall pattern that switches mode now and then, plus one long hold-off
  initial begin : receiver
    stall_mode_e stall_mode;
    int          mode_left;
    stall_mode = STALL_NONE;
    mode_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 80);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:      out_stall_i <= 1'b0;
        STALL_LIGHT:     out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_ALTERNATE: out_stall_i <= ~out_stall_i;
        default:         out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_channel(out_item_o);
  end

  initial begin : stimulus
    int          phase_base;
    int          frame_no;
    int          kind;
    logic [7:0]  lead;
    logic [7:0]  tail;
    int          cut;
    sb = new();
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_START_MARKER;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray byte with no frame, start during a frame, full-scale good
    // frame with both flags set, then a byte after the end that must be ignored
    send_byte(8'hFF, 1'b0);
    send_frame(START_MARKER_RST, 8'h00, 8'h00, 3, FILL_RANDOM);
    send_frame(START_MARKER_RST, 8'h0C, END_MARKER_RST, LAST_POS + 1, FILL_ONES);
    send_byte(8'h00, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1:       program_markers(8'h00, 8'hFF);
          2:       program_markers(8'hFF, 8'h00);
          4:       program_markers(START_MARKER_RST, END_MARKER_RST);
          default: program_markers(8'($urandom), 8'($urandom));
        endcase
      end
      phase_base = items_sent;
      frame_no   = 0;
      while (items_sent - phase_base < PHASE_ITEMS) begin
        // receiver holds off while the sender keeps going, so the block backs up
        if (phase == 1 && frame_no == 1) hold_off_req = 1'b1;
        // sender pause until every owed result has come out
        if (phase == 3 && frame_no == 1) wait_drained();
        kind = $urandom_range(0, 99);
        lead = sb.start_marker;
        tail = sb.end_marker;
        cut  = LAST_POS + 1;
        if (kind >= 70 && kind < 80) lead = lead ^ (8'h01 << $urandom_range(0, 7));
        else if (kind >= 80 && kind < 88) tail = tail ^ (8'h01 << $urandom_range(0, 7));
        else if (kind >= 88 && kind < 95) cut = $urandom_range(1, LAST_POS);
        if (kind >= 95) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        end else begin
          send_frame(lead, 8'($urandom), tail, cut, fill_e'($urandom_range(0, 3)));
        end
        frame_no++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_channels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d results still owed", $time, sb.pending_channels.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
